/* src/bscm_pkg.sv */
// bscm_pkg: shared types and constants for the battery safety constraint merge block
// holds the configuration struct, the queued item struct and the register index codes
// no dependencies
package bscm_pkg;

    // stale status limit in ms
    localparam logic [31:0] TIMEOUT_MS = 32'd1500;

    // stream widths, padded to whole bytes
    localparam int unsigned IN_TDATA_W  = 120;
    localparam int unsigned OUT_TDATA_W = 72;

    // filter state after reset, 100 kW scaled by 256
    localparam logic [23:0] FILTER_RESET = 24'd256000;
    // ceil(2^29 / 5) for the divide by five
    localparam logic [26:0] DIV5_RECIP   = 27'd107374183;

    // configuration register indexes
    localparam logic [1:0] REG_RATED_POWER  = 2'd0;
    localparam logic [1:0] REG_OVL_THRESH   = 2'd1;
    localparam logic [1:0] REG_OVL_HYST     = 2'd2;
    localparam logic [1:0] REG_EXTREME      = 2'd3;

    // configuration register set
    typedef struct packed {
        logic [15:0] rated_power;
        logic [10:0] ovl_thresh;
        logic [9:0]  overload_hysteresis;
        logic [11:0] extreme_ratio;
    } t_cfg;

    // one classified item between front and back
    typedef struct packed {
        logic        chg_allow;
        logic        dis_allow;
        logic [15:0] max_charge_request;
        logic [15:0] max_discharge_request;
        logic [31:0] now_time_ms;
        logic        stale;
        logic        over_thresh;
        logic        over_extreme;
        logic        release_ok;
        logic [16:0] overload_cap;
    } t_item;

endpackage

/* src/bscm_front.sv */
// bscm_front: configuration registers and per-beat classification
// computes staleness, load ratio tests and the overload cap; uses bscm_pkg
module bscm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    input  logic [bscm_pkg::IN_TDATA_W-1:0]    i_tdata,
    output bscm_pkg::t_item                    o_item
);
    import bscm_pkg::*;

    t_cfg        r_cfg;
    logic [15:0] max_charge_request;
    logic [15:0] max_discharge_request;
    logic [31:0] status_stamp_ms;
    logic [31:0] now_time_ms;
    logic [15:0] load_power;
    logic [31:0] age;
    logic [27:0] scaled_load;
    logic [27:0] thr_level;
    logic [27:0] ext_level;
    logic [27:0] rel_level;
    logic [27:0] cap_diff;
    logic [10:0] rel_ratio;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rated_power         <= 16'd2250;
            r_cfg.ovl_thresh          <= 11'd973;
            r_cfg.overload_hysteresis <= 10'd20;
            r_cfg.extreme_ratio       <= 12'd1126;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_RATED_POWER: r_cfg.rated_power         <= i_cfg_data;
                REG_OVL_THRESH:  r_cfg.ovl_thresh          <= i_cfg_data[10:0];
                REG_OVL_HYST:    r_cfg.overload_hysteresis <= i_cfg_data[9:0];
                REG_EXTREME:     r_cfg.extreme_ratio       <= i_cfg_data[11:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // unpack the input beat
    assign max_charge_request    = i_tdata[17:2];
    assign max_discharge_request = i_tdata[33:18];
    assign status_stamp_ms       = i_tdata[65:34];
    assign now_time_ms           = i_tdata[97:66];
    assign load_power            = i_tdata[113:98];

    // status age, negative counts as fresh
    assign age = now_time_ms - status_stamp_ms;

    // load ratio tests by cross multiplication
    assign scaled_load = {2'b00, load_power, 10'b0};
    assign thr_level   = 28'(r_cfg.ovl_thresh) * 28'(r_cfg.rated_power);
    assign ext_level   = 28'(r_cfg.extreme_ratio) * 28'(r_cfg.rated_power);
    assign rel_ratio   = r_cfg.ovl_thresh - {1'b0, r_cfg.overload_hysteresis};
    assign rel_level   = 28'(rel_ratio) * 28'(r_cfg.rated_power);
    assign cap_diff    = thr_level - scaled_load;

    // classified item
    always_comb begin
        o_item.chg_allow             = i_tdata[0];
        o_item.dis_allow             = i_tdata[1];
        o_item.max_charge_request    = max_charge_request;
        o_item.max_discharge_request = max_discharge_request;
        o_item.now_time_ms           = now_time_ms;
        o_item.stale                 = !age[31] && (age > TIMEOUT_MS);
        o_item.over_thresh           = scaled_load > thr_level;
        o_item.over_extreme          = scaled_load > ext_level;
        o_item.release_ok            = (r_cfg.ovl_thresh > {1'b0, r_cfg.overload_hysteresis})
                                       && (scaled_load < rel_level);
        o_item.overload_cap          = (thr_level > scaled_load) ? cap_diff[26:10] : 17'd0;
    end

endmodule

/* src/bscm_queue.sv */
// bscm_queue: two-entry queue of classified items between front and back
// uses bscm_pkg for the item type
module bscm_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  bscm_pkg::t_item i_item,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output bscm_pkg::t_item o_item
);
    import bscm_pkg::*;

    t_item       r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'(i_push) - 2'(i_pop);
        end
    end

endmodule

/* src/bscm_back.sv */
// bscm_back: debounce, limit filters, overload latch and the output register
// takes classified items from the queue; uses bscm_pkg
module bscm_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_q_empty,
    input  bscm_pkg::t_item                   i_item,
    output logic                              o_pop,
    input  logic                              i_tready,
    output logic                              o_tvalid,
    output logic [bscm_pkg::OUT_TDATA_W-1:0]  o_tdata
);
    import bscm_pkg::*;

    // y = floor((256x + 4y) / 5) by reciprocal multiply, exact below 2^27
    function automatic logic [23:0] filter_next(input logic [23:0] y, input logic [15:0] x);
        logic [26:0] sum;
        logic [53:0] prod;
        sum  = {3'b000, x, 8'b0} + {1'b0, y, 2'b00};
        prod = 54'(sum) * 54'(DIV5_RECIP);
        return prod[52:29];
    endfunction

    logic        r_charge_block;
    logic        r_discharge_block;
    logic        r_last_charge;
    logic        r_last_discharge;
    logic [23:0] r_charge_filter;
    logic [23:0] r_discharge_filter;
    logic        r_latch;
    logic        r_tvalid;
    logic [OUT_TDATA_W-1:0] r_tdata;

    logic        n_charge_block;
    logic        n_discharge_block;
    logic        n_last_charge;
    logic        n_last_discharge;
    logic [23:0] n_charge_filter;
    logic [23:0] n_discharge_filter;
    logic        n_latch;
    logic [15:0] chg_ceiling;
    logic [15:0] dis_ceiling;
    logic        dis_blk;

    // pop when the output register is free or being drained
    assign o_pop    = !i_q_empty && (!r_tvalid || i_tready);
    assign o_tvalid = r_tvalid;
    assign o_tdata  = r_tdata;

    // next state for one item
    always_comb begin
        n_charge_block     = r_charge_block;
        n_discharge_block  = r_discharge_block;
        n_last_charge      = r_last_charge;
        n_last_discharge   = r_last_discharge;
        n_charge_filter    = r_charge_filter;
        n_discharge_filter = r_discharge_filter;
        if (i_item.stale) begin
            n_charge_block     = 1'b1;
            n_discharge_block  = 1'b1;
            n_charge_filter    = 24'd0;
            n_discharge_filter = 24'd0;
        end else begin
            if (i_item.chg_allow == r_last_charge) begin
                n_charge_block = !i_item.chg_allow;
            end
            if (i_item.dis_allow == r_last_discharge) begin
                n_discharge_block = !i_item.dis_allow;
            end
            n_last_charge      = i_item.chg_allow;
            n_last_discharge   = i_item.dis_allow;
            n_charge_filter    = filter_next(r_charge_filter, i_item.max_charge_request);
            n_discharge_filter = filter_next(r_discharge_filter, i_item.max_discharge_request);
        end

        // overload latch with hysteresis
        priority if (!r_latch && i_item.over_thresh) begin
            n_latch = 1'b1;
        end else if (r_latch && i_item.release_ok) begin
            n_latch = 1'b0;
        end else begin
            n_latch = r_latch;
        end

        // merged limits
        chg_ceiling = n_charge_filter[23:8];
        dis_ceiling = n_discharge_filter[23:8];
        if (n_latch && (i_item.overload_cap < {1'b0, dis_ceiling})) begin
            dis_ceiling = i_item.overload_cap[15:0];
        end
        dis_blk = n_discharge_block || i_item.over_extreme;
        if (n_charge_block) begin
            chg_ceiling = 16'd0;
        end
        if (dis_blk) begin
            dis_ceiling = 16'd0;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_charge_block     <= 1'b0;
            r_discharge_block  <= 1'b0;
            r_last_charge      <= 1'b1;
            r_last_discharge   <= 1'b1;
            r_charge_filter    <= FILTER_RESET;
            r_discharge_filter <= FILTER_RESET;
            r_latch            <= 1'b0;
            r_tvalid           <= 1'b0;
        end else begin
            if (o_pop) begin
                r_charge_block     <= n_charge_block;
                r_discharge_block  <= n_discharge_block;
                r_last_charge      <= n_last_charge;
                r_last_discharge   <= n_last_discharge;
                r_charge_filter    <= n_charge_filter;
                r_discharge_filter <= n_discharge_filter;
                r_latch            <= n_latch;
                r_tvalid           <= 1'b1;
            end else if (i_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    // output beat register
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_tdata <= {4'b0000, i_item.now_time_ms, i_item.over_extreme, n_latch,
                        dis_ceiling, chg_ceiling, dis_blk, n_charge_block};
        end
    end

endmodule

/* src/battery_safety_constraint_merge_top.sv */
// battery_safety_constraint_merge_top: top level of the battery safety constraint merge
// depends on bscm_pkg, bscm_front, bscm_queue and bscm_back

// Merges battery controller enables, filtered power limits and a transformer overload
// cap into one result beat per input beat. The block takes one beat per clock cycle while
// the queue is not full; the limit filter update (an add and a reciprocal multiply feeding
// back into its own register) sets that pace. Each result beat passes through the queue and
// the output register. A front stage classifies each beat (status age, load ratio tests,
// overload cap) into a two-entry queue, and a back stage applies debounce, filters and the
// overload latch into an output register, so input and output stall independently.
// Configuration writes are always taken (o_cfg_ready is tied high) and must only be
// issued while no beat is in flight.
module battery_safety_constraint_merge_top (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [1:0]                         i_cfg_index,
    input  logic [15:0]                        i_cfg_data,
    // input stream
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // tdata from bit 0: chg_allow, dis_allow, max_charge_request[16],
    // max_discharge_request[16], status_stamp_ms[32], now_time_ms[32], load_power[16], pad
    input  logic [bscm_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // output stream
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // tdata from bit 0: chg_blk, dis_blk, chg_ceiling[16],
    // dis_ceiling[16], overload_limiting, ext_overload, result_stamp_ms[32], pad
    output logic [bscm_pkg::OUT_TDATA_W-1:0]   o_m_axis_tdata
);
    import bscm_pkg::*;

    t_item front_item;
    t_item head_item;
    logic  q_full;
    logic  q_empty;
    logic  q_push;
    logic  q_pop;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !q_full;
    assign q_push          = i_s_axis_tvalid && !q_full;

    // classification front
    bscm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_tdata     (i_s_axis_tdata),
        .o_item      (front_item)
    );

    // decoupling queue
    bscm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (front_item),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_item  (head_item)
    );

    // state update back
    bscm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_item    (head_item),
        .o_pop     (q_pop),
        .i_tready  (i_m_axis_tready),
        .o_tvalid  (o_m_axis_tvalid),
        .o_tdata   (o_m_axis_tdata)
    );

endmodule

/* src/bscm_checker.sv */
// bscm_port_checker: port-level assertions for the battery safety constraint merge top
// bound to battery_safety_constraint_merge_top; uses bscm_pkg widths
module bscm_port_checker (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_tvalid,
    input  logic                              i_tready,
    input  logic [bscm_pkg::OUT_TDATA_W-1:0]  i_tdata
);
    import bscm_pkg::*;

    // blocked charge reports zero limit
    a_charge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && i_tdata[0] |-> i_tdata[17:2] == 16'd0)
        else $error("charge blocked with nonzero limit");

    // blocked discharge reports zero limit
    a_discharge_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && i_tdata[1] |-> i_tdata[33:18] == 16'd0)
        else $error("discharge blocked with nonzero limit");

    // extreme overload forces discharge block
    a_extreme_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && i_tdata[35] |-> i_tdata[1])
        else $error("extreme overload without discharge block");

    // no result right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_tvalid)
        else $error("result beat valid after reset");

    // stalled beat holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_tvalid && !i_tready |=> i_tvalid && $stable(i_tdata))
        else $error("stalled result beat changed");

endmodule

bind battery_safety_constraint_merge_top bscm_port_checker u_bscm_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_tvalid (o_m_axis_tvalid),
    .i_tready (i_m_axis_tready),
    .i_tdata  (o_m_axis_tdata)
);
